/* src/uwfde_pkg.sv */
// Shared types, codes and decode helpers for the unwind table FDE lookup block.
package uwfde_pkg;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_LOOKUP = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_BAD_ENC = 2'd1,
      STAT_FULL    = 2'd2
   } status_type;

   // csr register indexes
   localparam logic [2:0] CSR_TABLE_ENC = 3'd0;
   localparam logic [2:0] CSR_PC_BASE   = 3'd1;
   localparam logic [2:0] CSR_TEXT_BASE = 3'd2;
   localparam logic [2:0] CSR_DATA_BASE = 3'd3;
   localparam logic [2:0] CSR_FUNC_BASE = 3'd4;

   localparam logic [7:0] TABLE_ENC_RESET = 8'h3B;

   // relative base, encoding bits 6..4
   localparam logic [2:0] BASE_ABS  = 3'd0;
   localparam logic [2:0] BASE_PC   = 3'd1;
   localparam logic [2:0] BASE_TEXT = 3'd2;
   localparam logic [2:0] BASE_DATA = 3'd3;
   localparam logic [2:0] BASE_FUNC = 3'd4;

   // value type, encoding bits 3..0
   localparam logic [3:0] TY_ABSPTR = 4'h0;
   localparam logic [3:0] TY_UDATA2 = 4'h2;
   localparam logic [3:0] TY_UDATA4 = 4'h3;
   localparam logic [3:0] TY_UDATA8 = 4'h4;
   localparam logic [3:0] TY_SIGNED = 4'h8;
   localparam logic [3:0] TY_SDATA2 = 4'hA;
   localparam logic [3:0] TY_SDATA4 = 4'hB;
   localparam logic [3:0] TY_SDATA8 = 4'hC;

   typedef enum logic [1:0] {
      SZ_2 = 2'd0,
      SZ_4 = 2'd1,
      SZ_8 = 2'd2
   } size_type;

   typedef struct packed {
      logic     ok;
      logic     sgn;
      size_type size;
   } enc_info_type;

   function automatic enc_info_type enc_info(input logic [7:0] enc);
      enc_info_type info;
      info.ok   = 1'b1;
      info.sgn  = 1'b0;
      info.size = SZ_8;
      unique case (enc[3:0])
         TY_ABSPTR, TY_UDATA8: info.size = SZ_8;
         TY_UDATA2:            info.size = SZ_2;
         TY_UDATA4:            info.size = SZ_4;
         TY_SIGNED, TY_SDATA8: begin
            info.size = SZ_8;
            info.sgn  = 1'b1;
         end
         TY_SDATA2: begin
            info.size = SZ_2;
            info.sgn  = 1'b1;
         end
         TY_SDATA4: begin
            info.size = SZ_4;
            info.sgn  = 1'b1;
         end
         default: info.ok = 1'b0;
      endcase
      if (enc[6:4] > BASE_FUNC) begin
         info.ok = 1'b0;
      end
      return info;
   endfunction

   // take the low bytes of a raw field and extend them
   function automatic logic [63:0] ext_field(input logic [63:0] raw, input size_type sz,
                                             input logic sgn);
      logic [63:0] v;
      unique case (sz)
         SZ_2:    v = {{48{sgn & raw[15]}}, raw[15:0]};
         SZ_4:    v = {{32{sgn & raw[31]}}, raw[31:0]};
         default: v = raw;
      endcase
      return v;
   endfunction

   function automatic logic [63:0] size_bytes(input size_type sz);
      logic [63:0] v;
      unique case (sz)
         SZ_2:    v = 64'd2;
         SZ_4:    v = 64'd4;
         default: v = 64'd8;
      endcase
      return v;
   endfunction

endpackage

/* src/uwfde_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module uwfde_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/unwind_table_fde_lookup_top.sv */
// Unwind table FDE lookup: sorted entry table with append, clear and binary-search lookup.
//
// Input channel (req_*, valid/ready) carries a command: clear, append or lookup.
// Result channel (rsp_*, valid/ready) returns exactly one result per transaction.
// csr_* is a write-only register port (encoding byte and the four base addresses);
// write it only while the block is idle.
// One transaction is handled at a time; req_ready is high only when the sequencer is idle.
// Path from acceptance to rsp_valid, each ending in the response step:
//   clear / other commands / failed append : straight to the response step
//   append                                 : four passes through the shared 64-bit adder
//   lookup                                 : k search steps, k <= ceil(log2(count+1))
//                                            (one table read plus one adder compare per step)
// Rate is bounded by the single table read port and the shared adder.
// A finished result sits in the output register; the next transaction is accepted
// while it waits. A stalled receiver holds the block only once a second result is ready.
// Reset (synchronous) empties the table, loads register reset values and drops rsp_valid.
// Table entries beyond the fill count are never read, so the RAM needs no clearing pass.
module unwind_table_fde_lookup_top
   import uwfde_pkg::*;
#(
   parameter int MAX_ENTRIES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [63:0] req_raw_start,
   input  logic [63:0] req_raw_offset,
   input  logic [63:0] req_query_pc,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [63:0] rsp_fde_pos,
   output logic [9:0]  rsp_entry_index,
   output logic [1:0]  rsp_status,
   // configuration
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wr_data
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_APPEND = 5'b00010,
      ST_RD     = 5'b00100,
      ST_CMP    = 5'b01000,
      ST_RESP   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [7:0]  table_enc_ff;
   logic [63:0] pc_base_ff, text_base_ff, data_base_ff, func_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_enc_ff <= TABLE_ENC_RESET;
         pc_base_ff   <= '0;
         text_base_ff <= '0;
         data_base_ff <= '0;
         func_base_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TABLE_ENC: table_enc_ff <= csr_wr_data[7:0];
            CSR_PC_BASE:   pc_base_ff   <= csr_wr_data;
            CSR_TEXT_BASE: text_base_ff <= csr_wr_data;
            CSR_DATA_BASE: data_base_ff <= csr_wr_data;
            CSR_FUNC_BASE: func_base_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   enc_info_type enc;
   logic         pc_rel;
   logic [63:0]  base_sel;

   assign enc    = enc_info(table_enc_ff);
   assign pc_rel = (table_enc_ff[6:4] == BASE_PC);

   always_comb begin
      unique case (table_enc_ff[6:4])
         BASE_PC:   base_sel = pc_base_ff;
         BASE_TEXT: base_sel = text_base_ff;
         BASE_DATA: base_sel = data_base_ff;
         BASE_FUNC: base_sel = func_base_ff;
         default:   base_sel = '0;
      endcase
   end

   // control and payload registers
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [IDX_W-1:0] mid_ff, mid_in;
   logic [1:0]       step_ff, step_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [63:0]      raw_start_ff, raw_start_in;
   logic [63:0]      raw_offset_ff, raw_offset_in;
   logic [63:0]      query_ff, query_in;
   logic [63:0]      acc_ff, acc_in;
   logic [63:0]      start_ff, start_in;
   logic             res_found_ff, res_found_in;
   logic [63:0]      res_fde_ff, res_fde_in;
   logic [IDX_W-1:0] res_idx_ff, res_idx_in;
   status_type       res_status_ff, res_status_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [63:0]      rsp_fde_ff, rsp_fde_in;
   logic [9:0]       rsp_idx_ff, rsp_idx_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;

   // shared 64-bit adder, also used as the search comparator
   logic [63:0] add_a, add_b;
   logic        add_cin;
   logic [64:0] add_sum;

   assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {64'd0, add_cin};

   // table memory: {start, offset}
   logic             ram_wr_en;
   logic             ram_rd_en;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [127:0]     ram_rd_data;

   uwfde_ram #(
      .WIDTH (128),
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({start_ff, add_sum[63:0]}),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   logic [63:0]      field_off;
   logic [63:0]      count_wide;
   logic [63:0]      vs, vo;
   logic [CNT_W:0]   mid_sum;
   logic [CNT_W-1:0] mid_cnt;
   logic [IDX_W+9:0] idx_wide;
   logic             req_fire;
   logic             rsp_load;

   assign count_wide = 64'(count_ff);
   always_comb begin
      unique case (enc.size)
         SZ_2:    field_off = count_wide << 2;
         SZ_4:    field_off = count_wide << 3;
         default: field_off = count_wide << 4;
      endcase
   end

   assign vs       = ext_field(raw_start_ff, enc.size, enc.sgn);
   assign vo       = ext_field(raw_offset_ff, enc.size, enc.sgn);
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_cnt  = mid_sum[CNT_W:1];
   assign idx_wide = {10'd0, res_idx_ff};
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign rsp_load  = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff;
      raw_start_in  = raw_start_ff;
      raw_offset_in = raw_offset_ff;
      query_in      = query_ff;
      acc_in        = acc_ff;
      start_in      = start_ff;
      res_found_in  = res_found_ff;
      res_fde_in    = res_fde_ff;
      res_idx_in    = res_idx_ff;
      res_status_in = res_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_fde_in    = rsp_fde_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_status_in = rsp_status_ff;
      add_a         = '0;
      add_b         = '0;
      add_cin       = 1'b0;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = mid_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               raw_start_in  = req_raw_start;
               raw_offset_in = req_raw_offset;
               query_in      = req_query_pc;
               res_found_in  = 1'b0;
               res_fde_in    = '1;
               res_idx_in    = '0;
               res_status_in = STAT_OK;
               step_in       = '0;
               lo_in         = '0;
               hi_in         = count_ff;
               state_in      = ST_RESP;
               unique case (req_command)
                  CMD_CLEAR: count_in = '0;
                  CMD_APPEND: begin
                     if (!enc.ok) begin
                        res_status_in = STAT_BAD_ENC;
                     end else if (count_ff == MAX_CNT) begin
                        res_status_in = STAT_FULL;
                     end else begin
                        state_in = ST_APPEND;
                     end
                  end
                  CMD_LOOKUP: begin
                     if (count_ff != '0) begin
                        state_in = ST_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_APPEND: begin
            // base (+ field position), start, next field position, offset
            step_in = step_ff + 2'd1;
            unique case (step_ff)
               2'd0: begin
                  add_a  = base_sel;
                  add_b  = pc_rel ? field_off : 64'd0;
                  acc_in = add_sum[63:0];
               end
               2'd1: begin
                  add_a    = acc_ff;
                  add_b    = vs;
                  start_in = add_sum[63:0];
               end
               2'd2: begin
                  add_a  = acc_ff;
                  add_b  = pc_rel ? size_bytes(enc.size) : 64'd0;
                  acc_in = add_sum[63:0];
               end
               default: begin
                  add_a      = acc_ff;
                  add_b      = vo;
                  ram_wr_en  = 1'b1;
                  res_fde_in = add_sum[63:0];
                  res_idx_in = count_ff[IDX_W-1:0];
                  count_in   = count_ff + CNT_W'(1);
                  state_in   = ST_RESP;
               end
            endcase
         end
         ST_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = mid_cnt[IDX_W-1:0];
            mid_in      = mid_cnt[IDX_W-1:0];
            state_in    = ST_CMP;
         end
         ST_CMP: begin
            // carry out of pc + ~start + 1 means start <= pc
            add_a   = query_ff;
            add_b   = ~ram_rd_data[127:64];
            add_cin = 1'b1;
            if (add_sum[64]) begin
               lo_in        = CNT_W'(mid_ff) + CNT_W'(1);
               res_found_in = 1'b1;
               res_fde_in   = ram_rd_data[63:0];
               res_idx_in   = mid_ff;
            end else begin
               hi_in = CNT_W'(mid_ff);
            end
            state_in = (lo_in < hi_in) ? ST_RD : ST_RESP;
         end
         ST_RESP: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = res_found_ff;
               rsp_fde_in    = res_fde_ff;
               rsp_idx_in    = idx_wide[9:0];
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         mid_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         mid_ff       <= mid_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_start_ff  <= raw_start_in;
      raw_offset_ff <= raw_offset_in;
      query_ff      <= query_in;
      acc_ff        <= acc_in;
      start_ff      <= start_in;
      res_found_ff  <= res_found_in;
      res_fde_ff    <= res_fde_in;
      res_idx_ff    <= res_idx_in;
      res_status_ff <= res_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_fde_ff    <= rsp_fde_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_fde_pos     = rsp_fde_ff;
   assign rsp_entry_index = rsp_idx_ff;
   assign rsp_status      = rsp_status_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("entry count beyond table depth");

   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (CNT_W'(mid_ff) >= lo_ff) && (CNT_W'(mid_ff) < hi_ff))
      else $error("search probe outside the lo/hi window");

   a_hi_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD || state_ff == ST_CMP) |-> (hi_ff <= count_ff))
      else $error("search upper bound past fill count");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && res_found_ff) |-> (res_status_ff == STAT_OK))
      else $error("hit reported with error status");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("result raised outside the response step");
`endif

endmodule

/* verif/tb_top.sv */
// Testbench for the unwind table FDE lookup block: queued driver, table predictor, result checker.
`timescale 1ns / 1ps

module tb_top
   import uwfde_pkg::*;
();

   localparam int          DEPTH    = 1024;
   localparam logic [1:0]  CMD_NOP  = 2'd3;   // undefined command, leaves the table alone
   localparam logic [63:0] ALL_ONES = '1;
   localparam int          N_PHASES = 10;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [63:0] raw_start;
      logic [63:0] raw_offset;
      logic [63:0] query_pc;
      logic        drain_first;   // hold this transaction back until all results are in
   } req_item_type;

   typedef struct packed {
      logic        found;
      logic [63:0] fde_pos;
      logic [9:0]  entry_index;
      status_type  status;
   } fde_result_type;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command    = CMD_CLEAR;
   logic [63:0] req_raw_start  = '0;
   logic [63:0] req_raw_offset = '0;
   logic [63:0] req_query_pc   = '0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic        rsp_found;
   logic [63:0] rsp_fde_pos;
   logic [9:0]  rsp_entry_index;
   logic [1:0]  rsp_status;
   logic        csr_wr_en      = 1'b0;
   logic [2:0]  csr_index      = CSR_TABLE_ENC;
   logic [63:0] csr_wr_data    = '0;

   // predictor copy of the table and registers
   logic [63:0] entry_start  [DEPTH];
   logic [63:0] entry_offset [DEPTH];
   int          entry_fill;
   logic [7:0]  enc_reg;
   logic [63:0] pc_base_reg, text_base_reg, data_base_reg, func_base_reg;

   req_item_type   pending_reqs[$];
   fde_result_type expected_rsps[$];
   req_item_type   in_flight, next_req;
   fde_result_type want;

   // stimulus generator: running start value and decoded starts of the current run
   logic [63:0] seq_value;
   logic [63:0] seq_starts[$];

   int send_idle_pct, recv_stall_pct;
   int n_fail, n_accepted, n_stored, n_hits, n_misses, n_full, n_bad_enc, n_clears;
   int p, k, w;

   logic [7:0] phase_enc [N_PHASES] = '{8'h00, 8'h1B, 8'h22, 8'h3C, 8'h43,
                                        8'h8A, 8'h14, 8'h48, 8'h09, 8'hF3};

   unwind_table_fde_lookup_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_raw_start   (req_raw_start),
      .req_raw_offset  (req_raw_offset),
      .req_query_pc    (req_query_pc),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_fde_pos     (rsp_fde_pos),
      .rsp_entry_index (rsp_entry_index),
      .rsp_status      (rsp_status),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   always #6 clock = ~clock;

   // bytes per encoded field, 0 for LEB128, unknown types and unsupported bases
   function automatic int field_bytes(input logic [7:0] enc);
      int n;
      case (enc[3:0])
         TY_UDATA2, TY_SDATA2:                       n = 2;
         TY_UDATA4, TY_SDATA4:                       n = 4;
         TY_ABSPTR, TY_UDATA8, TY_SIGNED, TY_SDATA8: n = 8;
         default:                                    n = 0;
      endcase
      if (enc[6:4] > BASE_FUNC) n = 0;
      return n;
   endfunction

   function automatic logic [63:0] decode_ptr(input logic [63:0] raw, input int nbytes,
                                              input logic [63:0] field_pos);
      logic [63:0] v;
      logic        sgn;
      sgn = enc_reg[3];
      case (nbytes)
         2:       v = {{48{sgn & raw[15]}}, raw[15:0]};
         4:       v = {{32{sgn & raw[31]}}, raw[31:0]};
         default: v = raw;
      endcase
      case (enc_reg[6:4])
         BASE_PC:   v = pc_base_reg + field_pos + v;
         BASE_TEXT: v = text_base_reg + v;
         BASE_DATA: v = data_base_reg + v;
         BASE_FUNC: v = func_base_reg + v;
         default:   ;
      endcase
      return v;
   endfunction

   function automatic fde_result_type predict_fde(input req_item_type it);
      fde_result_type r;
      int             nbytes, lo, hi, mid;
      logic [63:0]    pos;
      r.found       = 1'b0;
      r.fde_pos     = ALL_ONES;
      r.entry_index = '0;
      r.status      = STAT_OK;
      case (it.cmd)
         CMD_CLEAR: begin
            entry_fill = 0;
            n_clears++;
         end
         CMD_APPEND: begin
            nbytes = field_bytes(enc_reg);
            // bad encoding takes precedence over a full table
            if (nbytes == 0) begin
               r.status = STAT_BAD_ENC;
               n_bad_enc++;
            end else if (entry_fill >= DEPTH) begin
               r.status = STAT_FULL;
               n_full++;
            end else begin
               pos = 64'(entry_fill) * 64'(2 * nbytes);
               entry_start[entry_fill]  = decode_ptr(it.raw_start, nbytes, pos);
               entry_offset[entry_fill] = decode_ptr(it.raw_offset, nbytes, pos + 64'(nbytes));
               r.fde_pos     = entry_offset[entry_fill];
               r.entry_index = 10'(entry_fill);
               entry_fill++;
               n_stored++;
            end
         end
         CMD_LOOKUP: begin
            lo = 0;
            hi = entry_fill;
            while (lo < hi) begin
               mid = (lo + hi) / 2;
               if (entry_start[mid] <= it.query_pc) lo = mid + 1;
               else hi = mid;
            end
            if (lo > 0) begin
               r.found       = 1'b1;
               r.fde_pos     = entry_offset[lo - 1];
               r.entry_index = 10'(lo - 1);
               n_hits++;
            end else begin
               n_misses++;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsps.push_back(predict_fde(in_flight));
            n_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() > 0) next_req = pending_reqs[0];
            if (pending_reqs.size() > 0 && !(next_req.drain_first && expected_rsps.size() > 0)
                && $urandom_range(0, 99) >= send_idle_pct) begin
               in_flight = pending_reqs.pop_front();
               req_command    <= in_flight.cmd;
               req_raw_start  <= in_flight.raw_start;
               req_raw_offset <= in_flight.raw_offset;
               req_query_pc   <= in_flight.query_pc;
               req_valid      <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic check_field(input string name, input logic [63:0] want_v,
                              input logic [63:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want_v, got_v);
         n_fail++;
      end
   endtask

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: result with nothing expected: found %b fde %h index %0d status %0d",
                     $time, rsp_found, rsp_fde_pos, rsp_entry_index, rsp_status);
            n_fail++;
         end else begin
            want = expected_rsps.pop_front();
            check_field("found", 64'(want.found), 64'(rsp_found));
            check_field("fde_pos", want.fde_pos, rsp_fde_pos);
            check_field("entry_index", 64'(want.entry_index), 64'(rsp_entry_index));
            check_field("status", 64'(want.status), 64'(rsp_status));
         end
      end
   end

   initial begin
      #10_000_000;
      $display("run timed out waiting for the block");
      $display("tb_top NOT OK");
      $finish;
   end

   function automatic logic [63:0] rand_wide();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return ALL_ONES;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // random junk above the bytes the encoding uses
   function automatic logic [63:0] with_junk(input logic [63:0] v, input int nbytes);
      logic [63:0] r;
      r = {$urandom, $urandom};
      case (nbytes)
         2:       r[15:0] = v[15:0];
         4:       r[31:0] = v[31:0];
         default: r = v;
      endcase
      return r;
   endfunction

   function automatic logic [63:0] pick_pc();
      logic [63:0] s;
      if (seq_starts.size() == 0 || $urandom_range(0, 9) == 0) return rand_wide();
      s = seq_starts[$urandom_range(0, seq_starts.size() - 1)];
      case ($urandom_range(0, 3))
         0:       return s - 64'd1;
         1:       return s + 64'd1;
         2:       return s + 64'($urandom_range(0, 64));
         default: return s;
      endcase
   endfunction

   task automatic push_req(input logic [1:0] cmd, input logic [63:0] rs, input logic [63:0] ro,
                           input logic [63:0] pc, input logic drain);
      req_item_type it;
      it.cmd         = cmd;
      it.raw_start   = rs;
      it.raw_offset  = ro;
      it.query_pc    = pc;
      it.drain_first = drain;
      pending_reqs.push_back(it);
   endtask

   task automatic restart_run(input int nbytes);
      seq_starts.delete();
      case (nbytes)
         2:       seq_value = enc_reg[3] ? {48'hFFFF_FFFF_FFFF, 16'h8AD0}
                                         : 64'($urandom_range(0, 1000));
         4:       seq_value = {32'h0, $urandom};
         default: seq_value = {1'b0, 31'($urandom), $urandom};
      endcase
   endtask

   // next entry of an ascending run, random content in unused bytes and offsets
   task automatic push_sorted_append(input int nbytes);
      logic [63:0] rs;
      seq_value = seq_value + ((nbytes == 2) ? 64'($urandom_range(0, 40))
                                             : 64'($urandom_range(0, 1 << 20)));
      rs = with_junk(seq_value, nbytes);
      if (nbytes != 0)
         seq_starts.push_back(decode_ptr(rs, nbytes, 64'(seq_starts.size() * 2 * nbytes)));
      push_req(CMD_APPEND, rs, rand_wide(), rand_wide(), 1'b0);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      case (idx)
         CSR_TABLE_ENC: enc_reg       = data[7:0];
         CSR_PC_BASE:   pc_base_reg   = data;
         CSR_TEXT_BASE: text_base_reg = data;
         CSR_DATA_BASE: data_base_reg = data;
         CSR_FUNC_BASE: func_base_reg = data;
         default:       ;
      endcase
   endtask

   task automatic csr_release();
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_config(input logic [7:0] enc, input logic [63:0] pcb, input logic [63:0] tb,
                             input logic [63:0] db, input logic [63:0] fb);
      csr_write(CSR_TABLE_ENC, {56'(rand_wide()) , enc});
      csr_write(CSR_PC_BASE, pcb);
      csr_write(CSR_TEXT_BASE, tb);
      csr_write(CSR_DATA_BASE, db);
      csr_write(CSR_FUNC_BASE, fb);
      csr_release();
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         1:       begin send_idle_pct = 59; recv_stall_pct = 0;  end
         2:       begin send_idle_pct = 0;  recv_stall_pct = 59; end
         3:       begin send_idle_pct = 26; recv_stall_pct = 26; end
         default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_mixed_phase(input int n_items);
      int nbytes, r, i;
      nbytes = field_bytes(enc_reg);
      restart_run(nbytes);
      push_req(CMD_CLEAR, rand_wide(), rand_wide(), rand_wide(), 1'b0);
      for (i = 0; i < n_items; i++) begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            push_sorted_append(nbytes);
         end else if (r < 85) begin
            push_req(CMD_LOOKUP, rand_wide(), rand_wide(), pick_pc(), $urandom_range(0, 49) == 0);
         end else if (r < 90) begin
            push_req(CMD_CLEAR, rand_wide(), rand_wide(), rand_wide(), 1'b0);
            restart_run(nbytes);
         end else if (r < 94) begin
            push_req(CMD_NOP, rand_wide(), rand_wide(), rand_wide(), 1'b0);
         end else if (r < 97) begin
            push_req(CMD_APPEND, rand_wide(), rand_wide(), rand_wide(), 1'b0);
         end else begin
            push_req(CMD_LOOKUP, rand_wide(), rand_wide(), rand_wide(), 1'b0);
         end
      end
   endtask

   function automatic logic [63:0] pick_base();
      case ($urandom_range(0, 2))
         0:       return '0;
         1:       return ALL_ONES;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      entry_fill    = 0;
      enc_reg       = TABLE_ENC_RESET;
      pc_base_reg   = '0;
      text_base_reg = '0;
      data_base_reg = '0;
      func_base_reg = '0;
      n_fail = 0; n_accepted = 0; n_stored = 0; n_hits = 0;
      n_misses = 0; n_full = 0; n_bad_enc = 0; n_clears = 0;
      set_idling(0);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: reset encoding is signed 4-byte, data relative, base zero
      push_req(CMD_LOOKUP, '0, '0, '0, 1'b0);                    // empty table
      push_req(CMD_LOOKUP, '0, '0, ALL_ONES, 1'b0);
      push_req(CMD_NOP, ALL_ONES, ALL_ONES, ALL_ONES, 1'b0);
      push_req(CMD_CLEAR, '0, '0, '0, 1'b0);
      push_req(CMD_APPEND, 64'hA5A5_A5A5_0000_1000, 64'h0000_0000_8000_0000, '0, 1'b0);
      push_req(CMD_APPEND, 64'h5A5A_5A5A_0000_1000, 64'h0000_0000_7FFF_FFFF, '0, 1'b0);
      push_req(CMD_APPEND, 64'h0000_0000_7FFF_FFFF, ALL_ONES, '0, 1'b0);
      push_req(CMD_APPEND, 64'hFFFF_FFFF_8000_0000, '0, '0, 1'b0);   // negative start
      push_req(CMD_LOOKUP, '0, '0, 64'h0FFF, 1'b0);               // below every start
      push_req(CMD_LOOKUP, '0, '0, 64'h1000, 1'b0);               // duplicate starts
      push_req(CMD_LOOKUP, '0, '0, 64'h7FFF_FFFE, 1'b0);
      push_req(CMD_LOOKUP, '0, '0, 64'h7FFF_FFFF, 1'b0);
      push_req(CMD_LOOKUP, '0, '0, ALL_ONES, 1'b0);
      push_req(CMD_LOOKUP, '0, '0, '0, 1'b0);
      push_req(CMD_CLEAR, ALL_ONES, ALL_ONES, ALL_ONES, 1'b0);
      push_req(CMD_LOOKUP, '0, '0, 64'h1000, 1'b0);
      wait_idle();
      csr_write(CSR_TABLE_ENC, 64'hFF);                           // unknown type
      csr_release();
      push_req(CMD_APPEND, ALL_ONES, ALL_ONES, '0, 1'b0);
      push_req(CMD_LOOKUP, '0, '0, ALL_ONES, 1'b0);
      wait_idle();
      csr_write(CSR_TABLE_ENC, 64'h50);                           // unsupported base
      csr_release();
      push_req(CMD_APPEND, '0, '0, '0, 1'b0);
      wait_idle();

      for (p = 0; p < N_PHASES; p++) begin
         set_idling(p % 4);
         set_config(phase_enc[p], pick_base(), pick_base(), pick_base(), pick_base());
         run_mixed_phase(45);
         wait_idle();

         if (p == 4) begin
            // fill the table to the last index, overflow it, then search it
            set_idling(3);
            set_config(8'h1A, {16'h0000, 16'($urandom), 32'h0}, pick_base(), pick_base(),
                       pick_base());
            restart_run(2);
            push_req(CMD_CLEAR, '0, '0, '0, 1'b0);
            for (k = 0; k < DEPTH; k++) begin
               push_sorted_append(2);
               if (k % 128 == 127) push_req(CMD_LOOKUP, '0, '0, pick_pc(), 1'b0);
            end
            for (k = 0; k < 3; k++) push_req(CMD_APPEND, rand_wide(), rand_wide(), '0, 1'b0);
            push_req(CMD_LOOKUP, '0, '0, pick_pc(), 1'b1);
            for (k = 0; k < 60; k++) push_req(CMD_LOOKUP, '0, '0, pick_pc(), 1'b0);
            wait_idle();
            // full table and bad encoding together: encoding error wins
            csr_write(CSR_TABLE_ENC, 64'h0D);
            csr_release();
            push_req(CMD_APPEND, rand_wide(), rand_wide(), '0, 1'b0);
            for (k = 0; k < 5; k++) push_req(CMD_LOOKUP, '0, '0, pick_pc(), 1'b0);
            push_req(CMD_CLEAR, '0, '0, '0, 1'b0);
            wait_idle();
         end
      end

      while (pending_reqs.size() != 0 || req_valid) @(posedge clock);
      for (w = 0; w < 5000 && expected_rsps.size() != 0; w++) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_rsps.size());
         n_fail += expected_rsps.size();
      end
      repeat (40) @(posedge clock);

      $display("Covered %0d transactions: %0d entries stored, %0d lookup hits, %0d misses, %0d clears",
               n_accepted, n_stored, n_hits, n_misses, n_clears);
      $display("  %0d appends to a full table, %0d with bad encoding, %0d failures",
               n_full, n_bad_enc, n_fail);
      if (n_fail == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
